// ===== hdl/ring_deque_with_unordered_remove_core_defines.svh =====
// Assertion macros shared by the checker of the ring deque core.
`ifndef RING_DEQUE_WITH_UNORDERED_REMOVE_CORE_DEFINES_SVH
`define RING_DEQUE_WITH_UNORDERED_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring deque check failed");

`endif

// ===== hdl/rdq_pkg.sv =====
// Shared constants, codes and types of the ring deque core.
`default_nettype none
package rdq_pkg;

  localparam int DEPTH       = 256;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ELEM_W      = 32;
  localparam int REQ_W       = 2;
  localparam int LEN_W       = 9;
  localparam int OFF_W       = 8;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_READ       = 2'd2,
    REQ_REMOVE     = 2'd3
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_BAD_OFF = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEM
  } state_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic issue_rd;
    logic fin_now;
    logic fin_mem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_mem;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/rdq_ctrl.sv =====
// Controller state machine of the ring deque core.
`default_nettype none
module rdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire rdq_pkg::sts_t sts,
  output rdq_pkg::cmd_t      cmd
);

  rdq_pkg::state_e_t state_r;
  rdq_pkg::state_e_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      rdq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = rdq_pkg::ST_EXEC;
        end
      end
      rdq_pkg::ST_EXEC: begin
        if (sts.needs_mem) begin
          cmd.issue_rd = 1'b1;
          state_nxt    = rdq_pkg::ST_MEM;
        end else if (sts.out_free) begin
          cmd.fin_now = 1'b1;
          state_nxt   = rdq_pkg::ST_IDLE;
        end
      end
      rdq_pkg::ST_MEM: begin
        if (sts.out_free) begin
          cmd.fin_mem = 1'b1;
          state_nxt   = rdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/rdq_datapath.sv =====
// Datapath of the ring deque core: slot memory, pointers and result register.
`default_nettype none
module rdq_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [rdq_pkg::REQ_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rdq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [rdq_pkg::STAT_W-1:0]           out_tuser,
  input  wire rdq_pkg::cmd_t                   cmd,
  output rdq_pkg::sts_t                        sts
);

  localparam int AW = rdq_pkg::ADDR_W;
  localparam int CW = rdq_pkg::CNT_W;
  localparam int EW = rdq_pkg::ELEM_W;
  localparam int LW = rdq_pkg::LEN_W;
  localparam int OW = rdq_pkg::OFF_W;

  logic [EW-1:0] mem [rdq_pkg::DEPTH];
  logic [EW-1:0] rdata_r;

  rdq_pkg::req_e_t req_r;
  logic [EW-1:0]   data_r;
  logic [LW-1:0]   blen_r;
  logic [OW-1:0]   off_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [AW-1:0] bptr_r, bptr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [EW-1:0]     out_data_r, out_data_nxt;
  logic [rdq_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [CW-1:0]     out_occ_r, out_occ_nxt;
  logic              load_out;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  logic          is_push;
  logic          off_ok;
  logic [LW-1:0] len_eff;
  logic [CW-1:0] free_cnt;
  logic [AW-1:0] tgt_addr;
  logic [AW-1:0] start_ptr;
  logic [AW-1:0] front_head;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= rdq_pkg::req_e_t'(in_tuser);
      data_r <= in_tdata[EW-1:0];
      blen_r <= in_tdata[EW+LW-1:EW];
      off_r  <= in_tdata[EW+LW+OW-1:EW+LW];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign is_push    = (req_r == rdq_pkg::REQ_PUSH_BACK) || (req_r == rdq_pkg::REQ_PUSH_FRONT);
  assign off_ok     = {1'b0, off_r} < held_r;
  assign len_eff    = (blen_r == '0) ? LW'(1) : blen_r;
  assign free_cnt   = CW'(rdq_pkg::DEPTH) - held_r;
  assign tgt_addr   = head_r + off_r[AW-1:0];
  assign front_head = head_r - len_eff[AW-1:0];
  assign start_ptr  = (req_r == rdq_pkg::REQ_PUSH_BACK) ? head_r + held_r[AW-1:0] : front_head;

  assign sts.needs_mem = !is_push && off_ok;
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    head_nxt     = head_r;
    held_nxt     = held_r;
    left_nxt     = left_r;
    bptr_nxt     = bptr_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = tgt_addr;
    mem_wdata    = data_r;
    load_out     = 1'b0;
    out_data_nxt = out_data_r;
    out_stat_nxt = out_stat_r;
    if (cmd.issue_rd) begin
      mem_re   = 1'b1;
      mem_addr = (req_r == rdq_pkg::REQ_READ) ? tgt_addr : head_r;
    end
    if (cmd.fin_now) begin
      load_out     = 1'b1;
      out_data_nxt = '0;
      out_stat_nxt = rdq_pkg::STAT_OK;
      if (!is_push) begin
        out_stat_nxt = rdq_pkg::STAT_BAD_OFF;
      end else if (left_r != '0) begin
        mem_we   = 1'b1;
        mem_addr = bptr_r;
        bptr_nxt = bptr_r + AW'(1);
        left_nxt = left_r - LW'(1);
      end else if (len_eff > LW'(free_cnt)) begin
        out_stat_nxt = rdq_pkg::STAT_NO_ROOM;
      end else begin
        mem_we   = 1'b1;
        mem_addr = start_ptr;
        bptr_nxt = start_ptr + AW'(1);
        left_nxt = len_eff - LW'(1);
        held_nxt = held_r + CW'(len_eff);
        if (req_r == rdq_pkg::REQ_PUSH_FRONT) begin
          head_nxt = front_head;
        end
      end
    end
    if (cmd.fin_mem) begin
      load_out     = 1'b1;
      out_stat_nxt = rdq_pkg::STAT_OK;
      out_data_nxt = '0;
      if (req_r == rdq_pkg::REQ_READ) begin
        out_data_nxt = rdata_r;
      end else begin
        mem_we    = 1'b1;
        mem_addr  = tgt_addr;
        mem_wdata = rdata_r;
        head_nxt  = head_r + AW'(1);
        held_nxt  = held_r - CW'(1);
      end
    end
    out_occ_nxt   = load_out ? held_nxt : out_occ_r;
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      held_r      <= '0;
      left_r      <= '0;
      bptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      left_r      <= left_nxt;
      bptr_r      <= bptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(rdq_pkg::OUT_TDATA_W - EW - CW)'(0), out_occ_r, out_data_r};
  assign out_tuser  = out_stat_r;

endmodule
`default_nettype wire

// ===== hdl/ring_deque_with_unordered_remove_core.sv =====
// Ring deque of 256 elements of 32 bits with block push at either end, indexed read and
// unordered remove. A word is taken when the controller is idle and answered with one
// result word. A push or a rejected request is answered from the execute state; a read or
// a remove also passes a memory state, since the single-port slot memory is read first and
// then, for a remove, written with the head element. The next word is accepted in the
// cycle after a result is loaded, even while that result still waits at the output.
`default_nettype none
module ring_deque_with_unordered_remove_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // element_data[31:0], block_len[40:32], offset[48:41], zero fill above
  input  wire logic [rdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  wire logic [rdq_pkg::REQ_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // read_data[31:0], occupancy[40:32], zero fill above
  output logic [rdq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [rdq_pkg::STAT_W-1:0]           out_tuser
);

  rdq_pkg::cmd_t cmd;
  rdq_pkg::sts_t sts;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

// ===== hdl/rdq_checker.sv =====
// Port-level checker of the ring deque core and its bind.
`default_nettype none
`include "ring_deque_with_unordered_remove_core_defines.svh"
module rdq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [rdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [rdq_pkg::REQ_W-1:0]       in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rdq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [rdq_pkg::STAT_W-1:0]      out_tuser
);

  logic in_acc;
  logic err_res;

  assign in_acc  = in_tvalid && in_tready;
  assign err_res = out_tvalid && (out_tuser != rdq_pkg::STAT_OK);

  `RDQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `RDQ_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `RDQ_ASSERT_NOW(a_err_no_data, err_res, out_tdata[rdq_pkg::ELEM_W-1:0] == '0)
  `RDQ_ASSERT_NOW(a_occ_range, out_tvalid, out_tdata[40:32] <= 9'd256)
  `RDQ_ASSERT_NOW(a_status_code, out_tvalid, out_tuser != 2'd3)

endmodule

bind ring_deque_with_unordered_remove_core rdq_checker u_rdq_checker (.*);
`default_nettype wire
